### hdl/tc_pkg.sv
package tc_pkg;

  localparam int FRAME_INDEX_BITS_DEF = 48;

  localparam int RATE_W  = 8;
  localparam int DROP_W  = 5;
  localparam int NINE_W  = 8;
  localparam int MIN_W   = 14;
  localparam int TEN_W   = 18;
  localparam int HOUR_W  = 20;
  localparam int DAY_W   = 25;
  localparam int CIDX_W  = 8;

  localparam int HOURS_W   = 5;
  localparam int MINUTES_W = 6;
  localparam int SECONDS_W = 6;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_TEN  = 600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DROP_BASE     = 30;
  localparam int TENS_PER_DAY  = 144;
  localparam int DROP_MINUTES  = 9;

  localparam logic [RATE_W-1:0] RATE_RESET    = 8'd30;
  localparam logic              DROP_EN_RESET = 1'b0;

  // Register indexes on the configuration port
  localparam logic [CIDX_W-1:0] REG_NOMINAL_RATE      = 8'd0;
  localparam logic [CIDX_W-1:0] REG_DROP_FRAME_ENABLE = 8'd1;

  // Divisors and offsets derived from the configuration registers
  typedef struct packed {
    logic [RATE_W-1:0] nominal;
    logic              drop_on;
    logic [DROP_W-1:0] drop;
    logic [NINE_W-1:0] nine_drop;
    logic [MIN_W-1:0]  per_min;
    logic [TEN_W-1:0]  per_ten;
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hour_len;
    logic [MIN_W-1:0]  min_len;
  } cfg_t;

  // Labels skipped per dropped minute: 2 per 30 nominal frames, 0 if not a multiple of 30
  function automatic logic [DROP_W-1:0] drop_count(input logic [RATE_W-1:0] nominal);
    logic [DROP_W-1:0] d;
    d = '0;
    for (int k = 1; k <= 8; k++) begin
      if (nominal == RATE_W'(DROP_BASE * k)) d = DROP_W'(2 * k);
    end
    return d;
  endfunction

  function automatic cfg_t derive(input logic [RATE_W-1:0] rate, input logic drop_en);
    cfg_t c;
    c.nominal   = (rate == '0) ? RATE_W'(1) : rate;
    c.drop      = drop_en ? drop_count(c.nominal) : '0;
    c.drop_on   = (c.drop != '0);
    c.nine_drop = NINE_W'(c.drop) * NINE_W'(DROP_MINUTES);
    c.min_len   = MIN_W'(c.nominal) * MIN_W'(SECS_PER_MIN);
    c.per_min   = c.min_len - MIN_W'(c.drop);
    c.per_ten   = TEN_W'(c.nominal) * TEN_W'(SECS_PER_TEN) - TEN_W'(c.nine_drop);
    c.hour_len  = HOUR_W'(c.nominal) * HOUR_W'(SECS_PER_HOUR);
    c.day       = DAY_W'(c.nominal) * DAY_W'(SECS_PER_DAY)
                - DAY_W'(c.nine_drop) * DAY_W'(TENS_PER_DAY);
    return c;
  endfunction

endpackage

### hdl/frame_count_to_timecode.sv
// Frame count to timecode converter. A signed frame count enters on start and
// one timecode word (hh:mm:ss:ff, sign flag, drop-frame flag) leaves on
// result_valid_o. busy never rises: a new count may be started in every cycle,
// and results leave in order, one per cycle at most. The receiver cannot
// stall the result; each word is shown for a single cycle only. The pipeline
// is a chain of restoring dividers, one quotient bit per stage, with
// registers between them; the wrap modulo one day takes one stage per count
// bit. Configuration (nominal rate, drop-frame enable) is taken on every
// cycle but must only be written while no count is in flight.
module frame_count_to_timecode #(
  parameter int FRAME_INDEX_BITS = tc_pkg::FRAME_INDEX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [FRAME_INDEX_BITS-1:0] frame_index_i,
  // result channel
  output logic                              result_valid_o,
  output logic [tc_pkg::HOURS_W-1:0]        hours_o,
  output logic [tc_pkg::MINUTES_W-1:0]      minutes_o,
  output logic [tc_pkg::SECONDS_W-1:0]      seconds_o,
  output logic [tc_pkg::RATE_W-1:0]         frame_label_o,
  output logic                              is_negative_o,
  output logic                              is_drop_frame_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tc_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [tc_pkg::RATE_W-1:0]         cfg_data_i
);

  localparam int W   = FRAME_INDEX_BITS;
  localparam int LAT = W + 32;
  localparam int FW  = 2;  // flags: {neg, drop_on}

  // ---------------------------------------------------------------
  // Configuration: keep the raw registers and the derived divisors,
  // both updated on the same edge so a start right after a write sees them.
  // ---------------------------------------------------------------
  logic [tc_pkg::RATE_W-1:0] rate_q, rate_d;
  logic                      drop_en_q, drop_en_d;
  tc_pkg::cfg_t              cfg_q, cfg_d;
  logic                      cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    rate_d    = rate_q;
    drop_en_d = drop_en_q;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        tc_pkg::REG_NOMINAL_RATE:      rate_d    = cfg_data_i;
        tc_pkg::REG_DROP_FRAME_ENABLE: drop_en_d = cfg_data_i[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
    cfg_d = tc_pkg::derive(rate_d, drop_en_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= tc_pkg::RATE_RESET;
      drop_en_q <= tc_pkg::DROP_EN_RESET;
      cfg_q     <= tc_pkg::derive(tc_pkg::RATE_RESET, tc_pkg::DROP_EN_RESET);
    end else begin
      rate_q    <= rate_d;
      drop_en_q <= drop_en_d;
      cfg_q     <= cfg_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: take the magnitude. The most negative count negates to
  // 2**(W-1), which still fits the unsigned W-bit word.
  // ---------------------------------------------------------------
  logic          in_acc;
  logic          s0_valid_q;
  logic [W-1:0]  s0_mag_q;
  logic [FW-1:0] s0_flags_q;
  logic          neg;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;
  assign neg    = frame_index_i[W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_mag_q   <= neg ? (~frame_index_i + W'(1)) : frame_index_i;
    s0_flags_q <= {neg, cfg_q.drop_on};
  end

  // Wrap modulo one timecode day
  logic                     d1_valid;
  logic [tc_pkg::DAY_W-1:0] d1_idx;
  logic [FW-1:0]            d1_flags;

  tc_div_pipe #(.NW(W), .DW(tc_pkg::DAY_W), .QW(W), .SW(FW)) u_div_day (
    .clk_i, .rst_ni,
    .valid_i (s0_valid_q),
    .num_i   (s0_mag_q),
    .den_i   (cfg_q.day),
    .side_i  (s0_flags_q),
    .valid_o (d1_valid),
    .quo_o   (),
    .rem_o   (d1_idx),
    .side_o  (d1_flags)
  );

  // Split into ten-minute blocks
  logic                     d2_valid;
  logic [7:0]               d2_blocks;
  logic [tc_pkg::TEN_W-1:0] d2_within;
  logic [tc_pkg::DAY_W-1:0] d2_idx;
  logic [FW-1:0]            d2_flags;

  tc_div_pipe #(.NW(tc_pkg::DAY_W), .DW(tc_pkg::TEN_W), .QW(8),
                .SW(FW + tc_pkg::DAY_W)) u_div_ten (
    .clk_i, .rst_ni,
    .valid_i (d1_valid),
    .num_i   (d1_idx),
    .den_i   (cfg_q.per_ten),
    .side_i  ({d1_flags, d1_idx}),
    .valid_o (d2_valid),
    .quo_o   (d2_blocks),
    .rem_o   (d2_within),
    .side_o  ({d2_flags, d2_idx})
  );

  // Add back the labels skipped in whole ten-minute blocks
  logic                     l1_valid_q;
  logic [tc_pkg::DAY_W-1:0] l1_lab_q;
  logic [tc_pkg::TEN_W-1:0] l1_w_q;
  logic [FW-1:0]            l1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_valid_q <= 1'b0;
    end else begin
      l1_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_lab_q   <= d2_idx + tc_pkg::DAY_W'(cfg_q.nine_drop) * tc_pkg::DAY_W'(d2_blocks);
    // first minute of a block drops nothing: clamp so its quotient is zero
    l1_w_q     <= (d2_within >= tc_pkg::TEN_W'(cfg_q.drop))
                ? d2_within - tc_pkg::TEN_W'(cfg_q.drop) : '0;
    l1_flags_q <= d2_flags;
  end

  // Dropped minutes inside the block
  logic                     d3_valid;
  logic [3:0]               d3_mins;
  logic [tc_pkg::DAY_W-1:0] d3_lab;
  logic [FW-1:0]            d3_flags;

  tc_div_pipe #(.NW(tc_pkg::TEN_W), .DW(tc_pkg::MIN_W), .QW(4),
                .SW(FW + tc_pkg::DAY_W)) u_div_min (
    .clk_i, .rst_ni,
    .valid_i (l1_valid_q),
    .num_i   (l1_w_q),
    .den_i   (cfg_q.per_min),
    .side_i  ({l1_flags_q, l1_lab_q}),
    .valid_o (d3_valid),
    .quo_o   (d3_mins),
    .rem_o   (),
    .side_o  ({d3_flags, d3_lab})
  );

  logic                     l2_valid_q;
  logic [tc_pkg::DAY_W-1:0] l2_lab_q;
  logic [FW-1:0]            l2_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l2_valid_q <= 1'b0;
    end else begin
      l2_valid_q <= d3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    l2_lab_q   <= d3_lab + tc_pkg::DAY_W'(cfg_q.drop) * tc_pkg::DAY_W'(d3_mins);
    l2_flags_q <= d3_flags;
  end

  // Read off hours, minutes, seconds, frames
  logic                       d4_valid;
  logic [tc_pkg::HOURS_W-1:0] d4_hours;
  logic [tc_pkg::HOUR_W-1:0]  d4_rem;
  logic [FW-1:0]              d4_flags;

  tc_div_pipe #(.NW(tc_pkg::DAY_W), .DW(tc_pkg::HOUR_W), .QW(tc_pkg::HOURS_W),
                .SW(FW)) u_div_hour (
    .clk_i, .rst_ni,
    .valid_i (l2_valid_q),
    .num_i   (l2_lab_q),
    .den_i   (cfg_q.hour_len),
    .side_i  (l2_flags_q),
    .valid_o (d4_valid),
    .quo_o   (d4_hours),
    .rem_o   (d4_rem),
    .side_o  (d4_flags)
  );

  logic                         d5_valid;
  logic [tc_pkg::MINUTES_W-1:0] d5_minutes;
  logic [tc_pkg::MIN_W-1:0]     d5_rem;
  logic [tc_pkg::HOURS_W-1:0]   d5_hours;
  logic [FW-1:0]                d5_flags;

  tc_div_pipe #(.NW(tc_pkg::HOUR_W), .DW(tc_pkg::MIN_W), .QW(tc_pkg::MINUTES_W),
                .SW(FW + tc_pkg::HOURS_W)) u_div_minute (
    .clk_i, .rst_ni,
    .valid_i (d4_valid),
    .num_i   (d4_rem),
    .den_i   (cfg_q.min_len),
    .side_i  ({d4_flags, d4_hours}),
    .valid_o (d5_valid),
    .quo_o   (d5_minutes),
    .rem_o   (d5_rem),
    .side_o  ({d5_flags, d5_hours})
  );

  logic [FW-1:0] d6_flags;

  tc_div_pipe #(.NW(tc_pkg::MIN_W), .DW(tc_pkg::RATE_W), .QW(tc_pkg::SECONDS_W),
                .SW(FW + tc_pkg::HOURS_W + tc_pkg::MINUTES_W)) u_div_second (
    .clk_i, .rst_ni,
    .valid_i (d5_valid),
    .num_i   (d5_rem),
    .den_i   (cfg_q.nominal),
    .side_i  ({d5_flags, d5_hours, d5_minutes}),
    .valid_o (result_valid_o),
    .quo_o   (seconds_o),
    .rem_o   (frame_label_o),
    .side_o  ({d6_flags, hours_o, minutes_o})
  );

  assign is_negative_o   = d6_flags[1];
  assign is_drop_frame_o = d6_flags[0];

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##LAT result_valid_o)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(in_acc, LAT))
    else $error("result without a started count");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (is_negative_o == $past(frame_index_i[W-1], LAT)))
    else $error("sign flag does not match the started count");

endmodule

### hdl/tc_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, sideband rides along.
// Requires num_i < den_i * 2**QW; den_i must hold while words are in flight.
module tc_div_pipe #(
  parameter int NW = 25,
  parameter int DW = 18,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          valid_q [QW];
  logic [NW-1:0] rem_q   [QW];
  logic [QW-1:0] quo_q   [QW];
  logic [SW-1:0] side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic          vin;
    logic [NW-1:0] rin;
    logic [QW-1:0] qin;
    logic [SW-1:0] sin;
    logic [CW-1:0] shifted;
    logic          take;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign rin = num_i;
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = valid_q[k-1];
      assign rin = rem_q[k-1];
      assign qin = quo_q[k-1];
      assign sin = side_q[k-1];
    end

    assign shifted = CW'(den_i) << B;
    assign take    = (CW'(rin) >= shifted);
    assign rem_d   = take ? (rin - NW'(shifted)) : rin;
    assign quo_d   = take ? (qin | (QW'(1) << B)) : qin;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      quo_q[k]  <= quo_d;
      side_q[k] <= sin;
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign rem_o   = DW'(rem_q[QW-1]);
  assign side_o  = side_q[QW-1];

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

// Testbench for frame_count_to_timecode.
// Drive signed frame counts on the command channel and predict each timecode
// word from a local copy of the two configuration registers. Compare every
// result strobe, field by field, with the oldest predicted word. Run several
// phases, one per configuration setting, and write the registers only while
// no count is in flight.
module tb_top;

  localparam int FIB      = tc_pkg::FRAME_INDEX_BITS_DEF;
  localparam int LATENCY  = FIB + 32;
  localparam int LIMIT    = 3000000;

  typedef struct {
    logic [tc_pkg::HOURS_W-1:0]   hours;
    logic [tc_pkg::MINUTES_W-1:0] minutes;
    logic [tc_pkg::SECONDS_W-1:0] seconds;
    logic [tc_pkg::RATE_W-1:0]    frame_label;
    logic                         is_negative;
    logic                         is_drop_frame;
  } timecode_t;

  typedef struct {
    logic [FIB-1:0] count;
    int unsigned    gap;
  } count_word_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic signed [FIB-1:0]        frame_index_i;
  logic                         result_valid_o;
  logic [tc_pkg::HOURS_W-1:0]   hours_o;
  logic [tc_pkg::MINUTES_W-1:0] minutes_o;
  logic [tc_pkg::SECONDS_W-1:0] seconds_o;
  logic [tc_pkg::RATE_W-1:0]    frame_label_o;
  logic                         is_negative_o;
  logic                         is_drop_frame_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [tc_pkg::CIDX_W-1:0]    cfg_index_i;
  logic [tc_pkg::RATE_W-1:0]    cfg_data_i;

  frame_count_to_timecode #(.FRAME_INDEX_BITS(FIB)) uut (
    .clk_i, .rst_ni, .start, .busy, .frame_index_i,
    .result_valid_o, .hours_o, .minutes_o, .seconds_o, .frame_label_o,
    .is_negative_o, .is_drop_frame_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Local copy of the configuration registers
  logic [tc_pkg::RATE_W-1:0] rate_copy;
  logic                      drop_en_copy;

  count_word_t pending_counts[$];
  timecode_t   expected_codes[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned wait_left;
  bit          no_gaps;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Timecode arithmetic, all in 64 bits
  function automatic timecode_t to_timecode(input logic [FIB-1:0] raw);
    timecode_t tc;
    longint unsigned mag, nominal, drop, per_min, per_ten, day, idx, lab, blocks, rem_ten;
    logic neg, drop_on;
    neg = raw[FIB-1];
    mag = neg ? 64'(FIB'(~raw + 1'b1)) : 64'(raw);
    nominal = (rate_copy == 0) ? 1 : 64'(rate_copy);
    drop_on = drop_en_copy && (nominal % 30 == 0);
    drop = drop_on ? 2 * (nominal / 30) : 0;
    per_min = nominal * 60 - drop;
    per_ten = nominal * 600 - drop * 9;
    day = nominal * 86400 - drop * 9 * 144;
    idx = mag % day;
    lab = idx;
    if (drop_on) begin
      blocks = idx / per_ten;
      rem_ten = idx % per_ten;
      lab += drop * 9 * blocks;
      if (rem_ten >= drop) lab += drop * ((rem_ten - drop) / per_min);
    end
    tc.hours = tc_pkg::HOURS_W'((lab / (nominal * 3600)) % 24);
    tc.minutes = tc_pkg::MINUTES_W'((lab / (nominal * 60)) % 60);
    tc.seconds = tc_pkg::SECONDS_W'((lab / nominal) % 60);
    tc.frame_label = tc_pkg::RATE_W'(lab % nominal);
    tc.is_negative = neg;
    tc.is_drop_frame = drop_on;
    return tc;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Driver: hold start until the word is taken, then idle for the drawn gap
  always @(posedge clk_i or negedge rst_ni) begin
    count_word_t w;
    if (!rst_ni) begin
      start <= 1'b0;
      frame_index_i <= '0;
      wait_left <= 0;
    end else begin
      if (start && !busy) expected_codes.push_back(to_timecode(frame_index_i));
      if (start && busy) begin
        // hold the current word
      end else if (wait_left > 0) begin
        wait_left <= wait_left - 1;
        start <= 1'b0;
      end else if (pending_counts.size() > 0) begin
        w = pending_counts.pop_front();
        start <= 1'b1;
        frame_index_i <= w.count;
        wait_left <= w.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobe is one word, checked against the oldest prediction
  always @(posedge clk_i) begin
    timecode_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = expected_codes.pop_front();
        if (hours_o !== want.hours) report_mismatch("hours", hours_o, want.hours);
        if (minutes_o !== want.minutes) report_mismatch("minutes", minutes_o, want.minutes);
        if (seconds_o !== want.seconds) report_mismatch("seconds", seconds_o, want.seconds);
        if (frame_label_o !== want.frame_label)
          report_mismatch("frame_label", frame_label_o, want.frame_label);
        if (is_negative_o !== want.is_negative)
          report_mismatch("is_negative", is_negative_o, want.is_negative);
        if (is_drop_frame_o !== want.is_drop_frame)
          report_mismatch("is_drop_frame", is_drop_frame_o, want.is_drop_frame);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL frame_count_to_timecode");
      $finish;
    end
  end

  // Write one register through the config channel; hold valid until ready
  task automatic write_reg(input logic [tc_pkg::CIDX_W-1:0] idx,
                           input logic [tc_pkg::RATE_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == tc_pkg::REG_NOMINAL_RATE) rate_copy = data;
    else if (idx == tc_pkg::REG_DROP_FRAME_ENABLE) drop_en_copy = data[0];
  endtask

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic queue_count(input longint signed v);
    count_word_t w;
    w.count = FIB'(v);
    w.gap = draw_gap();
    pending_counts.push_back(w);
  endtask

  // Let every queued count leave and every prediction come back
  task automatic drain();
    do @(posedge clk_i);
    while (pending_counts.size() > 0 || start || expected_codes.size() > 0);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // Counts around day, ten-minute and minute boundaries of the current setting
  task automatic queue_boundaries();
    longint signed nominal, drop, per_min, per_ten, day;
    nominal = (rate_copy == 0) ? 1 : rate_copy;
    drop = (drop_en_copy && nominal % 30 == 0) ? 2 * (nominal / 30) : 0;
    per_min = nominal * 60 - drop;
    per_ten = nominal * 600 - drop * 9;
    day = nominal * 86400 - drop * 9 * 144;
    queue_count(0);
    queue_count(1);
    queue_count(-1);
    queue_count(day - 1);
    queue_count(day);
    queue_count(-day);
    queue_count(-3 * day);
    queue_count(per_min - 1);
    queue_count(per_min);
    queue_count(per_min + drop);
    queue_count(per_ten - 1);
    queue_count(per_ten);
    queue_count(per_ten + per_min + drop - 1);
  endtask

  task automatic queue_random(input int n);
    longint signed nominal, drop, per_min, per_ten, day, v;
    int kind;
    nominal = (rate_copy == 0) ? 1 : rate_copy;
    drop = (drop_en_copy && nominal % 30 == 0) ? 2 * (nominal / 30) : 0;
    per_min = nominal * 60 - drop;
    per_ten = nominal * 600 - drop * 9;
    day = nominal * 86400 - drop * 9 * 144;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 3);
      case (kind)
        0: begin
          v = longint'({$urandom, $urandom});
        end
        1: begin
          v = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (3 * day);
        end
        2: begin
          v = longint'($urandom_range(0, 200)) * per_ten
            + longint'($urandom_range(0, 9)) * per_min
            + longint'($urandom_range(0, 2 * drop + 2));
        end
        default: begin
          v = longint'($urandom_range(0, 30)) * day + longint'($urandom_range(0, 3)) - 1;
        end
      endcase
      if (kind != 0 && $urandom_range(0, 1)) v = -v;
      queue_count(v);
    end
  endtask

  typedef struct { logic [tc_pkg::RATE_W-1:0] rate; logic drop_en; } setting_t;

  initial begin
    setting_t plan[$];
    rate_copy = tc_pkg::RATE_RESET;
    drop_en_copy = tc_pkg::DROP_EN_RESET;
    no_gaps = 0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values first: 30 fps non-drop, with the sign extremes
    queue_boundaries();
    queue_count(longint'(48'h7FFF_FFFF_FFFF));
    queue_count(-longint'(48'h7FFF_FFFF_FFFF));
    queue_count(-longint'(48'h8000_0000_0000)); // most negative count
    queue_count(longint'(48'h5555_5555_5555));
    queue_count(longint'(48'h2AAA_AAAA_AAAA));
    drain();

    plan = '{'{8'd30, 1'b1}, '{8'd60, 1'b1}, '{8'd240, 1'b1}, '{8'd0, 1'b1},
             '{8'd1, 1'b0}, '{8'd255, 1'b1}, '{8'd241, 1'b0}, '{8'd25, 1'b1},
             '{8'd24, 1'b0}, '{8'd120, 1'b1}, '{8'd90, 1'b0}, '{8'd210, 1'b1},
             '{8'd30, 1'b0}};
    for (int r = 0; r < 3; r++) plan.push_back('{tc_pkg::RATE_W'($urandom_range(0, 255)),
                                                 1'($urandom_range(0, 1))});

    foreach (plan[p]) begin
      write_reg(tc_pkg::REG_NOMINAL_RATE, plan[p].rate);
      write_reg(tc_pkg::REG_DROP_FRAME_ENABLE, {7'($urandom), plan[p].drop_en});
      // Drop writes to indexes past the register list
      if (p % 4 == 0) write_reg(tc_pkg::CIDX_W'(2), tc_pkg::RATE_W'($urandom));
      if (p % 4 == 2) write_reg(tc_pkg::CIDX_W'(255), tc_pkg::RATE_W'($urandom));
      queue_boundaries();
      queue_random(75);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS frame_count_to_timecode");
    end else begin
      $display("FAIL frame_count_to_timecode");
    end
    $finish;
  end
endmodule

### sim.f
hdl/tc_pkg.sv
hdl/tc_div_pipe.sv
hdl/frame_count_to_timecode.sv
verif/tb_top.sv
